@@ src/gbfs_pkg.sv @@
`default_nettype none
package gbfs_pkg;

  localparam int unsigned MaxVertices  = 64;
  localparam int unsigned MaxListNodes = 512;
  localparam int unsigned VtxW  = $clog2(MaxVertices);
  localparam int unsigned NodeW = $clog2(MaxListNodes);
  localparam int unsigned PtrW  = $clog2(MaxListNodes + 1);
  localparam int unsigned CntW  = $clog2(MaxVertices + 1);
  localparam int unsigned CfgW  = 7;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_BFS   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [VtxW-1:0] first_vertex;
    logic [VtxW-1:0] second_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VtxW-1:0] visit_vertex;
    logic            last;
    logic [1:0]      status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR_SEEN,
    S_ADD_A,
    S_ADD_B,
    S_POP,
    S_HEAD,
    S_PTR,
    S_NODE,
    S_TAKE,
    S_EMIT_BFS,
    S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR_SEEN,
    OP_RD_A,
    OP_ADD_A,
    OP_ADD_B,
    OP_CLEAR,
    OP_BFS_INIT,
    OP_POP,
    OP_HEAD,
    OP_PTR,
    OP_NODE_RD,
    OP_NODE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       out_load;
    logic       out_bfs;
    status_e    out_status;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    req_e       req;
    logic       a_bad;
    logic       b_bad;
    logic       full;
    logic       clr_done;
    logic       fifo_empty;
    logic       ptr_null;
    logic       out_full;
  } sts_t;

endpackage
`default_nettype wire

@@ src/gbfs_datapath.sv @@
`default_nettype none
module gbfs_datapath
  import gbfs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire in_item_t  in_item_i,
  input  wire cmd_t      cmd_i,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output out_item_t      out_item_o,
  output sts_t           sts_o
);

  logic [CfgW-1:0] count_q;
  logic [VtxW-1:0] a_q, b_q;
  req_e            req_q;
  logic [PtrW-1:0] used_q;
  logic [MaxVertices-1:0] head_vld_q;
  logic [PtrW-1:0] head_mem [MaxVertices];
  logic [VtxW-1:0] nb_mem [MaxListNodes];
  logic [PtrW-1:0] link_mem [MaxListNodes];
  logic [MaxVertices-1:0] seen_q;
  logic [VtxW-1:0] fifo_mem [MaxVertices];
  logic [CntW-1:0] rd_q, wr_q;
  logic [VtxW-1:0] cur_q;
  logic [PtrW-1:0] ptr_q;
  logic [PtrW-1:0] head_q;
  logic [VtxW-1:0] nb_q;
  logic [PtrW-1:0] link_q;
  logic [VtxW-1:0] clr_q;
  logic            out_valid_q;
  out_item_t       out_q;
  logic [CntW-1:0] emitted_q;

  logic [CfgW-1:0] live;
  logic            nb_take;

  assign live = (count_q > CfgW'(MaxVertices)) ? CfgW'(MaxVertices) : count_q;
  assign nb_take = !seen_q[nb_q] && (wr_q < CntW'(MaxVertices));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CfgW'(MaxVertices);
      used_q      <= '0;
      head_vld_q  <= '0;
      seen_q      <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      emitted_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          clr_q <= '0;
        end
        OP_CLR_SEEN: begin
          seen_q[clr_q] <= 1'b0;
          clr_q <= clr_q + VtxW'(1);
        end
        OP_ADD_A: begin
          head_vld_q[a_q] <= 1'b1;
          used_q <= used_q + PtrW'(1);
        end
        OP_ADD_B: begin
          head_vld_q[b_q] <= 1'b1;
          used_q <= used_q + PtrW'(1);
        end
        OP_CLEAR: begin
          head_vld_q <= '0;
          used_q <= '0;
        end
        OP_BFS_INIT: begin
          seen_q[a_q] <= 1'b1;
          rd_q <= '0;
          wr_q <= CntW'(1);
          emitted_q <= '0;
        end
        OP_POP: begin
          rd_q <= rd_q + CntW'(1);
        end
        OP_NODE: begin
          if (nb_take) begin
            seen_q[nb_q] <= 1'b1;
            wr_q <= wr_q + CntW'(1);
          end
        end
        default: begin
        end
      endcase
      if (cmd_i.out_load && cmd_i.out_bfs) begin
        emitted_q <= emitted_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      a_q   <= in_item_i.first_vertex;
      b_q   <= in_item_i.second_vertex;
      req_q <= req_e'(in_item_i.req_type);
    end
    if (cmd_i.op == OP_RD_A) begin
      head_q <= head_mem[a_q];
    end
    if (cmd_i.op == OP_ADD_A) begin
      nb_mem[NodeW'(used_q)]   <= b_q;
      link_mem[NodeW'(used_q)] <= head_vld_q[a_q] ? head_q : '0;
      head_mem[a_q] <= used_q + PtrW'(1);
      head_q <= head_mem[b_q];
    end
    if (cmd_i.op == OP_ADD_B) begin
      nb_mem[NodeW'(used_q)]   <= a_q;
      // a self loop links to the node just added
      link_mem[NodeW'(used_q)] <= (a_q == b_q) ? used_q :
          (head_vld_q[b_q] ? head_q : '0);
      head_mem[b_q] <= used_q + PtrW'(1);
    end
    if (cmd_i.op == OP_BFS_INIT) begin
      fifo_mem[0] <= a_q;
    end
    if (cmd_i.op == OP_POP) begin
      cur_q <= fifo_mem[VtxW'(rd_q)];
    end
    if (cmd_i.op == OP_HEAD) begin
      head_q <= head_mem[cur_q];
    end
    if (cmd_i.op == OP_PTR) begin
      ptr_q <= head_vld_q[cur_q] ? head_q : '0;
    end
    if (cmd_i.op == OP_NODE_RD) begin
      nb_q   <= nb_mem[NodeW'(ptr_q - PtrW'(1))];
      link_q <= link_mem[NodeW'(ptr_q - PtrW'(1))];
    end
    if (cmd_i.op == OP_NODE) begin
      if (nb_take) begin
        fifo_mem[VtxW'(wr_q)] <= nb_q;
      end
      ptr_q <= link_q;
    end
    if (cmd_i.out_load) begin
      out_q.visit_vertex <= cmd_i.out_bfs ? cur_q : '0;
      out_q.status       <= cmd_i.out_status;
      out_q.last         <= cmd_i.out_bfs ?
          ((rd_q == wr_q) || (emitted_q == CntW'(MaxVertices - 1))) : cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    sts_o.req        = req_q;
    sts_o.a_bad      = {1'b0, a_q} >= live;
    sts_o.b_bad      = {1'b0, b_q} >= live;
    sts_o.full       = used_q > PtrW'(MaxListNodes - 2);
    sts_o.clr_done   = clr_q == VtxW'(MaxVertices - 1);
    sts_o.fifo_empty = (rd_q == wr_q) || (emitted_q == CntW'(MaxVertices));
    sts_o.ptr_null   = ptr_q == '0;
    sts_o.out_full   = out_valid_q && !out_ready_i;
  end

endmodule
`default_nettype wire

@@ src/gbfs_ctrl.sv @@
`default_nettype none
module gbfs_ctrl
  import gbfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    cmd_o.out_bfs  = 1'b0;
    cmd_o.out_status = ST_OK;
    cmd_o.out_last = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CLR_SEEN;
        end
      end
      S_CLR_SEEN: begin
        if (sts_i.req == REQ_BFS && !sts_i.a_bad) begin
          cmd_o.op = OP_CLR_SEEN;
          if (sts_i.clr_done) begin
            state_d = S_ADD_A;
          end
        end else begin
          cmd_o.op = OP_RD_A;
          state_d = S_ADD_A;
        end
      end
      S_ADD_A: begin
        case (sts_i.req)
          REQ_ADD: begin
            if (sts_i.a_bad || sts_i.b_bad) begin
              cmd_o.out_status = ST_RANGE;
              state_d = S_EMIT;
            end else if (sts_i.full) begin
              cmd_o.out_status = ST_FULL;
              state_d = S_EMIT;
            end else begin
              cmd_o.op = OP_ADD_A;
              state_d = S_ADD_B;
            end
          end
          REQ_BFS: begin
            if (sts_i.a_bad) begin
              cmd_o.out_status = ST_RANGE;
              state_d = S_EMIT;
            end else begin
              cmd_o.op = OP_BFS_INIT;
              state_d = S_POP;
            end
          end
          REQ_CLEAR: begin
            cmd_o.op = OP_CLEAR;
            state_d = S_EMIT;
          end
          default: begin
            state_d = S_EMIT;
          end
        endcase
        // clear, rejected and no-op requests wait here for the output register
        if (state_d == S_EMIT) begin
          if (sts_i.out_full) begin
            state_d = S_ADD_A;
          end else begin
            cmd_o.out_load = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_ADD_B: begin
        cmd_o.op = OP_ADD_B;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (sts_i.fifo_empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_POP;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_o.op = OP_HEAD;
        state_d  = S_PTR;
      end
      S_PTR: begin
        cmd_o.op = OP_PTR;
        state_d  = S_NODE;
      end
      S_NODE: begin
        if (sts_i.ptr_null) begin
          state_d = S_EMIT_BFS;
        end else begin
          cmd_o.op = OP_NODE_RD;
          state_d  = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_o.op = OP_NODE;
        state_d  = S_NODE;
      end
      S_EMIT_BFS: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_bfs  = 1'b1;
          state_d = S_POP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/graph_bfs_traversal_unit.sv @@
`default_nettype none
// Graph store with breadth-first traversal. One request is handled at a time.
// A traversal first resets the visited map one entry per cycle, then pops each
// visited vertex and walks its adjacency nodes through the registered reads
// of the head and node stores. A held-off output adds its wait. Each request
// gives its results in order on the output channel, last marked.
module graph_bfs_traversal_unit
  import gbfs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  cmd_t cmd;
  sts_t sts;

  gbfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbfs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire
